>>> sv/vga_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vga_pkg;

  localparam int COORD_W = 32;
  localparam int INTEN_W = 16;
  localparam int SID_W   = 64;
  localparam int OBS_W   = 32;
  localparam int SLOT_W  = 12;
  localparam int VSIZE_W = 31;
  localparam int SUM_W   = 64;
  localparam int ITOT_W  = 48;
  localparam int DIV_W   = 64;
  localparam int DVSR_W  = 32;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam int MIX_S1 = 30;
  localparam int MIX_S2 = 27;
  localparam int MIX_S3 = 31;

  localparam logic REG_BIN_SIZE = 1'b0;
  localparam logic REG_MIN_OBS  = 1'b1;

  typedef enum logic [1:0] {
    K_RAW  = 2'd0,
    K_AGG  = 2'd1,
    K_READ = 2'd2,
    K_NOP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_ADDED    = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_SKIPPED  = 2'd2,
    ST_REPORTED = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                      kind;
    logic                       oob;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic signed [COORD_W-1:0]  cz;
    logic [INTEN_W-1:0]         inten;
    logic [SID_W-1:0]           sid;
    logic [OBS_W-1:0]           prior;
    logic [SLOT_W-1:0]          slot;
  } item_t;

  typedef struct packed {
    logic                       used;
    logic signed [COORD_W-1:0]  kx;
    logic signed [COORD_W-1:0]  ky;
    logic signed [COORD_W-1:0]  kz;
    logic signed [SUM_W-1:0]    sx;
    logic signed [SUM_W-1:0]    sy;
    logic signed [SUM_W-1:0]    sz;
    logic [ITOT_W-1:0]          itot;
    logic [OBS_W-1:0]           pts;
    logic [OBS_W-1:0]           obs;
    logic [SID_W-1:0]           lsid;
    logic                       seen;
  } entry_t;

  typedef struct packed {
    status_t                    status;
    logic [COORD_W-1:0]         mx;
    logic [COORD_W-1:0]         my;
    logic [COORD_W-1:0]         mz;
    logic [INTEN_W-1:0]         mi;
    logic [OBS_W-1:0]           obs;
  } result_t;

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_BIN, B_HASH, B_MOD, B_PRB_RD, B_PRB_CHK,
    B_UPDATE, B_RD_RD, B_RD_CHK, B_MEAN, B_RESULT
  } bstate_t;

endpackage
`default_nettype wire

>>> sv/voxel_grid_accumulator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata point/read request, tuser action
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata means and count, tuser status
// cfg       in   cfg_we                       cfg_index, cfg_wdata
//
// a point takes three floor divisions for the bins,
// then hashing on one 32x32 multiplier, a read and a check per probe (TABLE_SLOTS a power of two)
// a slot read takes four divisions for the means
// the shared bit-serial divider serves both; one request in work at a time
// after reset a clearing pass over all TABLE_SLOTS entries runs with s_axis_tready low
// a two-entry queue parts intake from the table engine; results wait in m_axis
module voxel_grid_accumulator_unit #(
  parameter int TABLE_SLOTS = 4096,
  parameter int PROBE_LIMIT = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // coord_x, coord_y, coord_z, point_intensity, scan_id, prior_observations,
  // slot_index, zero pad
  input  wire logic [223:0]  s_axis_tdata,
  // action
  input  wire logic [1:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // mean_x, mean_y, mean_z, mean_intensity, voxel_observations
  output logic [143:0]       m_axis_tdata,
  // status
  output logic [1:0]         m_axis_tuser,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [31:0]   cfg_wdata
);
  import vga_pkg::*;

  logic [VSIZE_W-1:0] bin_size;
  logic [OBS_W-1:0]   min_obs;
  logic    push, queue_full, pop, not_empty, clear_done;
  item_t   push_item, pop_item;
  result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_size <= VSIZE_W'(65536);
      min_obs  <= OBS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIN_SIZE: bin_size <= cfg_wdata[VSIZE_W-1:0];
        REG_MIN_OBS:  min_obs  <= cfg_wdata;
      endcase
    end
  end

  vga_front #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .queue_full    (queue_full),
    .clear_done    (clear_done),
    .push          (push),
    .push_item     (push_item)
  );

  vga_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (not_empty)
  );

  vga_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (not_empty),
    .item       (pop_item),
    .item_pop   (pop),
    .bin_size   (bin_size),
    .min_obs    (min_obs),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (out_res),
    .clear_done (clear_done)
  );

  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {out_res.obs, out_res.mi, out_res.mz, out_res.my, out_res.mx};
endmodule
`default_nettype wire

>>> sv/vga_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module vga_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire vga_pkg::item_t push_item,
  output logic               full,
  input  wire logic          pop,
  output vga_pkg::item_t     pop_item,
  output logic               not_empty
);
  import vga_pkg::*;

  item_t      slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full      = (cnt == 2'd2);
  assign not_empty = (cnt != 2'd0);
  assign pop_item  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/vga_front.sv
`timescale 1ns / 1ps
`default_nettype none
module vga_front #(
  parameter int TABLE_SLOTS = 4096
) (
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [223:0]  s_axis_tdata,
  input  wire logic [1:0]    s_axis_tuser,
  input  wire logic          queue_full,
  input  wire logic          clear_done,
  output logic               push,
  output vga_pkg::item_t     push_item
);
  import vga_pkg::*;

  logic [SLOT_W-1:0] slot;

  assign slot          = s_axis_tdata[219:208];
  assign s_axis_tready = !queue_full && clear_done;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    push_item.kind  = kind_t'(s_axis_tuser);
    push_item.cx    = s_axis_tdata[31:0];
    push_item.cy    = s_axis_tdata[63:32];
    push_item.cz    = s_axis_tdata[95:64];
    push_item.inten = s_axis_tdata[111:96];
    push_item.sid   = s_axis_tdata[175:112];
    push_item.prior = s_axis_tdata[207:176];
    push_item.slot  = slot;
    push_item.oob   = (32'(slot) >= 32'(TABLE_SLOTS));
  end
endmodule
`default_nettype wire

>>> sv/vga_div.sv
`timescale 1ns / 1ps
`default_nettype none
module vga_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [vga_pkg::DIV_W-1:0]   dividend,
  input  wire logic [vga_pkg::DVSR_W-1:0]  divisor,
  output logic                             busy,
  output logic [vga_pkg::DIV_W-1:0]        quotient
);
  import vga_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DVSR_W-1:0] dvs;
  logic [DVSR_W-1:0] remainder;
  logic [CW-1:0]     cnt;
  logic [DVSR_W:0]   r_ext;
  logic [DVSR_W:0]   r_sub;
  logic              ge;

  assign r_ext = {remainder, quotient[DIV_W-1]};
  assign ge    = (r_ext >= {1'b0, dvs});
  assign r_sub = r_ext - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[DIV_W-2:0], ge};
      remainder <= ge ? r_sub[DVSR_W-1:0] : r_ext[DVSR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(DIV_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/vga_back.sv
`timescale 1ns / 1ps
`default_nettype none
module vga_back #(
  parameter int TABLE_SLOTS = 4096,
  parameter int PROBE_LIMIT = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  input  wire vga_pkg::item_t                item,
  output logic                               item_pop,
  input  wire logic [vga_pkg::VSIZE_W-1:0]   bin_size,
  input  wire logic [vga_pkg::OBS_W-1:0]     min_obs,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output vga_pkg::result_t                   out_res,
  output logic                               clear_done
);
  import vga_pkg::*;

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int PW = $clog2(PROBE_LIMIT + 1);

  bstate_t state, state_next;

  entry_t  mem [TABLE_SLOTS];
  entry_t  rdata;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;

  item_t   it;
  result_t res;
  entry_t  base;
  entry_t  claim;
  entry_t  upd;
  logic [1:0]  ax;
  logic [3:0]  hs;
  logic signed [COORD_W-1:0] bx, by, bz, cur_bin;
  logic [63:0] v, acc, prod, h;
  logic [AW-1:0] s;
  logic [PW-1:0] pc;
  logic [AW-1:0] clr;
  logic          div_run;

  logic              div_start;
  logic              div_busy;
  logic [DIV_W-1:0]  div_dvd;
  logic [DVSR_W-1:0] div_dvs;
  logic [DIV_W-1:0]  div_q;

  logic [63:0] mb, mul_a64, mul_b64, mul_p, mix_t, mix_in, fin, fin_sh;
  logic [31:0] mul_a, mul_b;
  logic signed [COORD_W-1:0] cur_c;
  logic [63:0] c_ext, bin_mag, dsz64;
  logic [DVSR_W-1:0] dsz;
  logic        bneg;
  logic [63:0] msum, mean_mag;
  logic        mneg;
  logic [31:0] q32, qres;
  logic        key_hit, full_voxel, report;
  logic [OBS_W-1:0] given;

  vga_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .quotient  (div_q)
  );

  assign clear_done = (state != B_CLEAR);

  // binning operands
  always_comb begin
    unique case (ax)
      2'd0:    cur_c = it.cx;
      2'd1:    cur_c = it.cy;
      default: cur_c = it.cz;
    endcase
    unique case (ax)
      2'd0:    cur_bin = bx;
      2'd1:    cur_bin = by;
      default: cur_bin = bz;
    endcase
    dsz     = (bin_size == '0) ? DVSR_W'(1) : {1'b0, bin_size};
    dsz64   = {32'd0, dsz};
    c_ext   = {{32{cur_c[31]}}, cur_c};
    bneg    = cur_c[31];
    bin_mag = bneg ? (-c_ext + dsz64 - 64'd1) : c_ext;
  end

  // mean operands
  always_comb begin
    unique case (ax)
      2'd0:    msum = base.sx;
      2'd1:    msum = base.sy;
      2'd2:    msum = base.sz;
      default: msum = {16'd0, base.itot};
    endcase
    mneg     = (ax != 2'd3) && msum[63];
    mean_mag = mneg ? (-msum + {32'd0, base.pts} - 64'd1) : msum;
    q32      = div_q[31:0];
    qres     = ((state == B_BIN) ? bneg : mneg) ? (~q32 + 32'd1) : q32;
  end

  // splitmix finalizer, low half products through one 32x32 multiplier
  always_comb begin
    mb = (hs < 4'd4) ? MIX_C1 : MIX_C2;
    unique case (hs)
      4'd2, 4'd6: begin
        mul_a = v[63:32];
        mul_b = mb[31:0];
      end
      4'd3, 4'd7: begin
        mul_a = v[31:0];
        mul_b = mb[63:32];
      end
      default: begin
        mul_a = v[31:0];
        mul_b = mb[31:0];
      end
    endcase
    mul_a64 = {32'd0, mul_a};
    mul_b64 = {32'd0, mul_b};
    mul_p   = mul_a64 * mul_b64;
    mix_t   = acc + {prod[31:0], 32'd0};
    mix_in  = {{32{cur_bin[31]}}, cur_bin};
    fin     = mix_t ^ (mix_t >> MIX_S3);
    unique case (ax)
      2'd0:    fin_sh = fin;
      2'd1:    fin_sh = fin << 1;
      default: fin_sh = fin << 7;
    endcase
  end

  // slot claim and update
  always_comb begin
    claim      = '0;
    claim.used = 1'b1;
    claim.kx   = bx;
    claim.ky   = by;
    claim.kz   = bz;
    key_hit    = (rdata.kx == bx) && (rdata.ky == by) && (rdata.kz == bz);
    full_voxel = (base.pts == '1);
    report     = rdata.used && (rdata.pts != '0) && (rdata.obs >= min_obs);
    given      = (it.prior == '0) ? OBS_W'(1) : it.prior;
    upd        = base;
    upd.sx     = base.sx + {{32{it.cx[31]}}, it.cx};
    upd.sy     = base.sy + {{32{it.cy[31]}}, it.cy};
    upd.sz     = base.sz + {{32{it.cz[31]}}, it.cz};
    upd.itot   = base.itot + {32'd0, it.inten};
    upd.pts    = base.pts + 32'd1;
    if (it.kind == K_RAW) begin
      if (!base.seen || (base.lsid != it.sid)) begin
        if (base.obs != '1) begin
          upd.obs = base.obs + 32'd1;
        end
        upd.lsid = it.sid;
        upd.seen = 1'b1;
      end
    end else begin
      if (given > base.obs) begin
        upd.obs = given;
      end
      upd.seen = 1'b1;
    end
  end

  // divider operand select
  always_comb begin
    unique case (state)
      B_MEAN: begin
        div_dvd = mean_mag;
        div_dvs = base.pts;
      end
      default: begin
        div_dvd = bin_mag;
        div_dvs = dsz;
      end
    endcase
  end

  assign raddr = (state == B_RD_RD) ? AW'(it.slot) : s;

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_pop   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = s;
    mem_wdata  = upd;
    div_start  = 1'b0;
    unique case (state)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        mem_wdata = '0;
        if (clr == AW'(TABLE_SLOTS - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          unique case (item.kind)
            K_RAW, K_AGG: state_next = B_BIN;
            K_READ:       state_next = item.oob ? B_RESULT : B_RD_RD;
            K_NOP:        state_next = B_RESULT;
          endcase
        end
      end
      B_BIN: begin
        if (!div_run) begin
          div_start = 1'b1;
        end else if (!div_busy && ax == 2'd2) begin
          state_next = B_HASH;
        end
      end
      B_HASH: begin
        if (hs == 4'd8 && ax == 2'd2) begin
          state_next = B_MOD;
        end
      end
      B_MOD: state_next = B_PRB_RD;
      B_PRB_RD: state_next = B_PRB_CHK;
      B_PRB_CHK: begin
        priority if (!rdata.used || key_hit) begin
          state_next = B_UPDATE;
        end else if (pc == PW'(PROBE_LIMIT - 1)) begin
          state_next = B_RESULT;
        end else begin
          state_next = B_PRB_RD;
        end
      end
      B_UPDATE: begin
        mem_we     = !full_voxel;
        state_next = B_RESULT;
      end
      B_RD_RD: state_next = B_RD_CHK;
      B_RD_CHK: state_next = report ? B_MEAN : B_RESULT;
      B_MEAN: begin
        if (!div_run) begin
          div_start = 1'b1;
        end else if (!div_busy && ax == 2'd3) begin
          state_next = B_RESULT;
        end
      end
      B_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      div_run   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        B_CLEAR: clr <= clr + 1'b1;
        B_IDLE: begin
          if (item_valid) begin
            it  <= item;
            res <= '{ST_SKIPPED, '0, '0, '0, '0, '0};
            ax  <= 2'd0;
            hs  <= 4'd0;
            h   <= '0;
          end
        end
        B_BIN: begin
          if (!div_run) begin
            div_run <= 1'b1;
          end else if (!div_busy) begin
            div_run <= 1'b0;
            unique case (ax)
              2'd0:    bx <= qres;
              2'd1:    by <= qres;
              default: bz <= qres;
            endcase
            ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
          end
        end
        B_HASH: begin
          unique case (hs)
            4'd0: v <= mix_in ^ (mix_in >> MIX_S1);
            4'd1, 4'd5: prod <= mul_p;
            4'd2, 4'd6: begin
              acc  <= prod;
              prod <= mul_p;
            end
            4'd3, 4'd7: begin
              acc  <= mix_t;
              prod <= mul_p;
            end
            4'd4: v <= mix_t ^ (mix_t >> MIX_S2);
            default: h <= h ^ fin_sh;
          endcase
          if (hs == 4'd8) begin
            hs <= 4'd0;
            ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
          end else begin
            hs <= hs + 4'd1;
          end
        end
        B_MOD: begin
          // home slot is the low hash bits
          s  <= h[AW-1:0];
          pc <= '0;
        end
        B_PRB_CHK: begin
          priority if (!rdata.used) begin
            base <= claim;
          end else if (key_hit) begin
            base <= rdata;
          end else begin
            pc <= pc + 1'b1;
            s  <= (s == AW'(TABLE_SLOTS - 1)) ? '0 : s + 1'b1;
            if (pc == PW'(PROBE_LIMIT - 1)) begin
              res.status <= ST_DROPPED;
            end
          end
        end
        B_UPDATE: res.status <= full_voxel ? ST_DROPPED : ST_ADDED;
        B_RD_CHK: begin
          base <= rdata;
          ax   <= 2'd0;
          if (report) begin
            res.status <= ST_REPORTED;
            res.obs    <= rdata.obs;
          end
        end
        B_MEAN: begin
          if (!div_run) begin
            div_run <= 1'b1;
          end else if (!div_busy) begin
            div_run <= 1'b0;
            unique case (ax)
              2'd0:    res.mx <= qres;
              2'd1:    res.my <= qres;
              2'd2:    res.mz <= qres;
              default: res.mi <= q32[INTEN_W-1:0];
            endcase
            ax <= ax + 2'd1;
          end
        end
        default: ;
      endcase

      if (state == B_RESULT && (!out_valid || out_ready)) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire
